// ===== sv/sapq_pkg.sv =====
// shared types and constants for the sorted array priority queue
package sapq_pkg;

  localparam int unsigned DefCapacity    = 8;
  localparam int unsigned DefPayloadBits = 32;

  typedef enum logic [0:0] {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_EXEC = 2'd1,
    CTL_RESP = 2'd2
  } ctl_state_e;

  // input word
  typedef struct packed {
    req_type_e          req_type;
    logic signed [15:0] priority_req;
    logic [31:0]        payload;
  } req_t;

  // result word
  typedef struct packed {
    status_e            status;
    logic signed [15:0] out_priority;
    logic [31:0]        out_payload;
    logic [3:0]         occupancy;
  } res_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  localparam logic signed [15:0] EmptyPriority = -16'sd1;

endpackage

// ===== sv/sapq_ctrl.sv =====
// controller state machine for the sorted array priority queue
module sapq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output sapq_pkg::cmd_t cmd_o
);
  import sapq_pkg::*;

  ctl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    busy       = 1'b0;
    done_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      CTL_IDLE: begin
        cmd_o.load = start;
        if (start) state_d = CTL_EXEC;
      end
      CTL_EXEC: begin
        busy       = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = CTL_RESP;
      end
      CTL_RESP: begin
        done_o     = 1'b1;
        cmd_o.load = start;
        state_d    = start ? CTL_EXEC : CTL_IDLE;
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

  // a taken word is always executed next cycle
  a_load_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec)
    else $error("load not followed by exec");

  // every execution is reported in the following cycle
  a_exec_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> done_o)
    else $error("exec not followed by result strobe");

  // no result strobe without a preceding execution
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_o.exec))
    else $error("result strobe without exec");

endmodule

// ===== sv/sapq_dp.sv =====
// datapath: sorted cell chain, request and result registers
module sapq_dp #(
  parameter int unsigned CAPACITY     = sapq_pkg::DefCapacity,
  parameter int unsigned PAYLOAD_BITS = sapq_pkg::DefPayloadBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sapq_pkg::cmd_t cmd_i,
  input  sapq_pkg::req_t req_i,
  output sapq_pkg::res_t res_o
);
  import sapq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  req_t                    req_q;
  res_t                    res_q, res_d;
  logic [CntW-1:0]         count_q, count_d;
  logic signed [15:0]      prio_q [CAPACITY];
  logic signed [15:0]      prio_d [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_q  [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_d  [CAPACITY];
  logic [CAPACITY-1:0]     gt;
  logic                    full, empty;
  logic [PAYLOAD_BITS+31:0] in_ext, out_ext;
  logic [CntW+3:0]         occ_ext;
  logic [PAYLOAD_BITS-1:0] new_pay;

  assign full  = (count_q == CntW'(CAPACITY));
  assign empty = (count_q == '0);

  // payload width adaption in and out
  assign in_ext  = {{PAYLOAD_BITS{1'b0}}, req_q.payload};
  assign new_pay = in_ext[PAYLOAD_BITS-1:0];
  assign out_ext = {32'd0, pay_q[0]};

  // request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // per-cell compare against the incoming priority
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CntW'(i) < count_q) && (prio_q[i] > req_q.priority_req);
    end
  end

  // cell next values: hold, shift back with insert, or shift forward
  always_comb begin
    count_d = count_q;
    for (int i = 0; i < CAPACITY; i++) begin
      prio_d[i] = prio_q[i];
      pay_d[i]  = pay_q[i];
    end
    if (cmd_i.exec) begin
      if (req_q.req_type == REQ_ENQ) begin
        if (!full) begin
          count_d = count_q + 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
              prio_d[i] = prio_q[(i > 0) ? i - 1 : 0];
              pay_d[i]  = pay_q[(i > 0) ? i - 1 : 0];
            end else if (gt[i] || (CntW'(i) == count_q)) begin
              prio_d[i] = req_q.priority_req;
              pay_d[i]  = new_pay;
            end
          end
        end
      end else if (!empty) begin
        count_d = count_q - 1'b1;
        for (int i = 0; i < CAPACITY - 1; i++) begin
          prio_d[i] = prio_q[i + 1];
          pay_d[i]  = pay_q[i + 1];
        end
      end
    end
  end

  // result word
  always_comb begin
    occ_ext            = {4'd0, count_d};
    res_d.status       = ST_ENQUEUED;
    res_d.out_priority = 16'sd0;
    res_d.out_payload  = 32'd0;
    res_d.occupancy    = occ_ext[3:0];
    if (req_q.req_type == REQ_ENQ) begin
      res_d.status = full ? ST_FULL : ST_ENQUEUED;
    end else if (empty) begin
      res_d.status       = ST_EMPTY;
      res_d.out_priority = EmptyPriority;
    end else begin
      res_d.status       = ST_DEQUEUED;
      res_d.out_priority = prio_q[0];
      res_d.out_payload  = out_ext[31:0];
    end
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // cell chain and result register
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      prio_q[i] <= prio_d[i];
      pay_q[i]  <= pay_d[i];
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  // count stays within capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // count only moves on execution
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(count_q))
    else $error("entry count changed while idle");

  // accepted enqueue grows the queue by one
  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && req_q.req_type == REQ_ENQ && !full
    |=> count_q == $past(count_q) + 1'b1)
    else $error("enqueue did not grow the queue");

  // dequeue on a non-empty queue returns the head priority
  a_deq_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && req_q.req_type == REQ_DEQ && !empty
    |=> res_q.out_priority == $past(prio_q[0]))
    else $error("dequeue did not return the head entry");

endmodule

// ===== sv/sorted_array_priority_queue.sv =====
// sorted array priority queue: latency 2 cycles from accept edge to result edge
// a word is taken at an edge with start high and busy low, executed in the next
// cycle, and its result is strobed by done_o in the cycle after that
// one word every 2 cycles: start may be raised again during the result cycle
// the receiver cannot stall; done_o lasts exactly one cycle
// reset (asynchronous, active low) empties the queue and returns to idle
module sorted_array_priority_queue #(
  parameter int unsigned CAPACITY     = sapq_pkg::DefCapacity,
  parameter int unsigned PAYLOAD_BITS = sapq_pkg::DefPayloadBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sapq_pkg::req_t req_i,
  output logic           done_o,
  output sapq_pkg::res_t res_o
);
  import sapq_pkg::*;

  cmd_t cmd;

  // controller
  sapq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // datapath
  sapq_dp #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .res_o  (res_o)
  );

endmodule
